// File: rtl/core/drt_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor ring tracker package
// Shared ring sizes, descriptor bit positions, codes and structure types.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

  // Ring sizes and the widths that follow from them
  localparam int TX_SLOTS = 4;
  localparam int RX_SLOTS = 4;
  localparam int TX_IW    = $clog2(TX_SLOTS);
  localparam int RX_IW    = $clog2(RX_SLOTS);
  localparam int OCC_W    = $clog2(TX_SLOTS + 1);
  localparam int GUARD_W  = $clog2(RX_SLOTS + 1);

  // Descriptor status word layout
  localparam int OWN_BIT      = 31;
  localparam int MORE_BIT     = 30;
  localparam int PKT_OK_BIT   = 27;
  localparam int TOO_LONG_BIT = 22;
  localparam int SIZE_W       = 12;

  localparam logic [SIZE_W-1:0] RX_SIZE_RESET = 12'd1536;
  localparam logic [SIZE_W-1:0] CRC_BYTES     = 12'd4;

  typedef enum logic [1:0] {
    OP_POST  = 2'd0,
    OP_TX_WB = 2'd1,
    OP_RX_WB = 2'd2,
    OP_POLL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_POST_OK   = 3'd0,
    K_OVERFLOW  = 3'd1,
    K_TX_OK     = 3'd2,
    K_TX_ERR    = 3'd3,
    K_RX_PKT    = 3'd4,
    K_RX_ERR    = 3'd5,
    K_POLL_DONE = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TX_REQ,
    ST_TX_CHK,
    ST_RX_REQ,
    ST_RX_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  slot;
    logic [11:0] length;
    logic [31:0] address;
    logic        last;
  } result_t;

  typedef struct packed {
    logic             re;
    logic [TX_IW-1:0] raddr;
    logic             stat_we;
    logic             addr_we;
    logic [TX_IW-1:0] waddr;
    logic [31:0]      stat_wdata;
    logic [31:0]      addr_wdata;
  } tx_mem_req_t;

  typedef struct packed {
    logic             re;
    logic [RX_IW-1:0] raddr;
    logic             we;
    logic [RX_IW-1:0] waddr;
    logic [31:0]      wdata;
  } rx_mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/drt_if.sv
// ----------------------------------------------------------------------------
// Descriptor ring tracker channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface drt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] frame_length;
  logic [31:0] buffer_address;
  logic [5:0]  slot;
  logic [31:0] status_word;
  logic        interrupt_pending;

  modport source (
    output valid, op, frame_length, buffer_address, slot, status_word,
           interrupt_pending,
    input  ready
  );
  modport sink (
    input  valid, op, frame_length, buffer_address, slot, status_word,
           interrupt_pending,
    output ready
  );
endinterface

interface drt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  result_slot;
  logic [11:0] result_length;
  logic [31:0] result_address;
  logic        last;

  modport source (
    output valid, kind, result_slot, result_length, result_address, last,
    input  ready
  );
  modport sink (
    input  valid, kind, result_slot, result_length, result_address, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/drt_tx_ram.sv
// ----------------------------------------------------------------------------
// Transmit descriptor store
// Status and buffer address per transmit slot, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_tx_ram (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire drt_pkg::tx_mem_req_t req_i,
  output logic [31:0]              stat_o,
  output logic [31:0]              addr_o
);
  import drt_pkg::*;

  logic [31:0]         stat_mem [TX_SLOTS];
  logic [31:0]         addr_mem [TX_SLOTS];
  logic [TX_SLOTS-1:0] vld_q;
  logic                rd_vld_q;
  logic [31:0]         stat_q;
  logic [31:0]         addr_q;

  // Written-entry flags: a slot never written reads as a free, all-zero status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.stat_we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // Storage arrays and the registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.stat_we) begin
      stat_mem[req_i.waddr] <= req_i.stat_wdata;
    end
    if (req_i.addr_we) begin
      addr_mem[req_i.waddr] <= req_i.addr_wdata;
    end
    if (req_i.re) begin
      stat_q <= stat_mem[req_i.raddr];
      addr_q <= addr_mem[req_i.raddr];
    end
  end

  assign stat_o = rd_vld_q ? stat_q : '0;
  assign addr_o = addr_q;

endmodule

`default_nettype wire

// File: rtl/core/drt_rx_ram.sv
// ----------------------------------------------------------------------------
// Receive descriptor store
// Status word per receive slot, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_rx_ram (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire drt_pkg::rx_mem_req_t req_i,
  output logic [31:0]              stat_o
);
  import drt_pkg::*;

  logic [31:0]         stat_mem [RX_SLOTS];
  logic [RX_SLOTS-1:0] vld_q;
  logic                rd_vld_q;
  logic [31:0]         stat_q;

  // Written-entry flags: an untouched slot reads as the reset buffer size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // Storage array and the registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      stat_mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      stat_q <= stat_mem[req_i.raddr];
    end
  end

  assign stat_o = rd_vld_q ? stat_q : {{(32-SIZE_W){1'b0}}, RX_SIZE_RESET};

endmodule

`default_nettype wire

// File: rtl/core/drt_ctrl.sv
// ----------------------------------------------------------------------------
// Descriptor ring tracker sequencer
// Takes requests, walks both rings through the descriptor stores and
// drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  drt_in_if.sink                 req_i,
  drt_out_if.source              rsp_o,
  input  wire logic [11:0]       buf_size_i,
  output drt_pkg::tx_mem_req_t   tx_req_o,
  input  wire logic [31:0]       tx_stat_i,
  input  wire logic [31:0]       tx_addr_i,
  output drt_pkg::rx_mem_req_t   rx_req_o,
  input  wire logic [31:0]       rx_stat_i
);
  import drt_pkg::*;

  state_e             state_q, state_d;
  logic [TX_IW-1:0]   wr_idx_q, wr_idx_d;
  logic [TX_IW-1:0]   reap_idx_q, reap_idx_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [RX_IW-1:0]   rd_idx_q, rd_idx_d;
  logic [GUARD_W-1:0] guard_q, guard_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic               in_fire;
  logic               out_free;
  logic               poll_start;
  logic               emit;
  result_t            res;
  logic               post_ok;
  logic               reap;
  logic               rx_take;
  logic               tx_full;
  logic               rx_good;
  logic [SIZE_W-1:0]  rx_size;
  logic [SIZE_W-1:0]  rx_len;
  op_e                op;

  assign op       = op_e'(req_i.op);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire  = req_i.valid && req_i.ready;
  assign poll_start = in_fire && (op == OP_POLL) && req_i.interrupt_pending;
  assign tx_full  = (occ_q == OCC_W'(TX_SLOTS));

  // Receive descriptor decode: good frame when packet-OK is up and more and too-long are down.
  assign rx_size = rx_stat_i[SIZE_W-1:0];
  assign rx_len  = (rx_size > CRC_BYTES) ? (rx_size - CRC_BYTES) : '0;
  assign rx_good = ({rx_stat_i[MORE_BIT], rx_stat_i[PKT_OK_BIT], rx_stat_i[TOO_LONG_BIT]}
                    == 3'b010);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (poll_start) begin
          state_d = ST_TX_REQ;
        end
      end
      ST_TX_REQ: begin
        state_d = (occ_q == '0) ? ST_RX_REQ : ST_TX_CHK;
      end
      ST_TX_CHK: begin
        if (tx_stat_i[OWN_BIT]) begin
          state_d = ST_RX_REQ;
        end else if (out_free) begin
          state_d = ST_TX_REQ;
        end
      end
      ST_RX_REQ: begin
        state_d = (guard_q == GUARD_W'(RX_SLOTS)) ? ST_DONE : ST_RX_CHK;
      end
      ST_RX_CHK: begin
        if (!rx_stat_i[OWN_BIT]) begin
          state_d = ST_DONE;
        end else if (out_free) begin
          state_d = ST_RX_REQ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic: store accesses, result generation and ring events.
  always_comb begin
    tx_req_o = '0;
    rx_req_o = '0;
    emit     = 1'b0;
    res      = '0;
    post_ok  = 1'b0;
    reap     = 1'b0;
    rx_take  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_POST: begin
              emit      = 1'b1;
              res.slot  = 6'(wr_idx_q);
              res.last  = 1'b1;
              if (tx_full) begin
                res.kind = K_OVERFLOW;
              end else begin
                res.kind            = K_POST_OK;
                post_ok             = 1'b1;
                tx_req_o.stat_we    = 1'b1;
                tx_req_o.addr_we    = 1'b1;
                tx_req_o.waddr      = wr_idx_q;
                tx_req_o.stat_wdata = {1'b1, 19'd0, req_i.frame_length};
                tx_req_o.addr_wdata = req_i.buffer_address;
              end
            end
            OP_TX_WB: begin
              if (req_i.slot < 6'(TX_SLOTS)) begin
                tx_req_o.stat_we    = 1'b1;
                tx_req_o.waddr      = req_i.slot[TX_IW-1:0];
                tx_req_o.stat_wdata = req_i.status_word;
              end
            end
            OP_RX_WB: begin
              if (req_i.slot < 6'(RX_SLOTS)) begin
                rx_req_o.we    = 1'b1;
                rx_req_o.waddr = req_i.slot[RX_IW-1:0];
                rx_req_o.wdata = req_i.status_word;
              end
            end
            OP_POLL: begin
              if (!req_i.interrupt_pending) begin
                emit     = 1'b1;
                res.kind = K_POLL_DONE;
                res.last = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TX_REQ: begin
        tx_req_o.re    = (occ_q != '0);
        tx_req_o.raddr = reap_idx_q;
      end
      ST_TX_CHK: begin
        if (!tx_stat_i[OWN_BIT] && out_free) begin
          emit                = 1'b1;
          reap                = 1'b1;
          res.kind            = tx_stat_i[PKT_OK_BIT] ? K_TX_OK : K_TX_ERR;
          res.slot            = 6'(reap_idx_q);
          res.address         = tx_addr_i;
          tx_req_o.stat_we    = 1'b1;
          tx_req_o.waddr      = reap_idx_q;
          tx_req_o.stat_wdata = '0;
        end
      end
      ST_RX_REQ: begin
        rx_req_o.re    = (guard_q != GUARD_W'(RX_SLOTS));
        rx_req_o.raddr = rd_idx_q;
      end
      ST_RX_CHK: begin
        if (rx_stat_i[OWN_BIT] && out_free) begin
          emit           = 1'b1;
          rx_take        = 1'b1;
          res.kind       = rx_good ? K_RX_PKT : K_RX_ERR;
          res.slot       = 6'(rd_idx_q);
          res.length     = rx_good ? rx_len : '0;
          rx_req_o.we    = 1'b1;
          rx_req_o.waddr = rd_idx_q;
          rx_req_o.wdata = {20'd0, buf_size_i};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          res.kind = K_POLL_DONE;
          res.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Ring pointers, occupancy and the receive walk bound.
  always_comb begin
    wr_idx_d   = wr_idx_q;
    reap_idx_d = reap_idx_q;
    occ_d      = occ_q;
    rd_idx_d   = rd_idx_q;
    guard_d    = guard_q;
    if (post_ok) begin
      wr_idx_d = (wr_idx_q == TX_IW'(TX_SLOTS - 1)) ? '0 : wr_idx_q + 1'b1;
      occ_d    = occ_q + 1'b1;
    end
    if (reap) begin
      reap_idx_d = (reap_idx_q == TX_IW'(TX_SLOTS - 1)) ? '0 : reap_idx_q + 1'b1;
      occ_d      = occ_q - 1'b1;
    end
    if (poll_start) begin
      guard_d = '0;
    end
    if (rx_take) begin
      rd_idx_d = (rd_idx_q == RX_IW'(RX_SLOTS - 1)) ? '0 : rd_idx_q + 1'b1;
      guard_d  = guard_q + 1'b1;
    end
  end

  // Result register: loaded whenever the previous transfer has gone.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      reap_idx_q  <= '0;
      occ_q       <= '0;
      rd_idx_q    <= '0;
      guard_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      reap_idx_q  <= reap_idx_d;
      occ_q       <= occ_d;
      rd_idx_q    <= rd_idx_d;
      guard_q     <= guard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.kind           = out_q.kind;
  assign rsp_o.result_slot    = out_q.slot;
  assign rsp_o.result_length  = out_q.length;
  assign rsp_o.result_address = out_q.address;
  assign rsp_o.last           = out_q.last;

  // Checks on the ring bookkeeping and the walk sequencing.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(TX_SLOTS))
    else $error("transmit occupancy above ring size");

  a_guard_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_q <= GUARD_W'(RX_SLOTS))
    else $error("receive walk went past the ring size");

  a_reap_needs_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TX_CHK) |-> (occ_q != '0))
    else $error("transmit check with an empty ring");

  a_poll_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_start |=> (state_q == ST_TX_REQ))
    else $error("poll with interrupt did not start the transmit walk");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == K_POLL_DONE)) |-> out_q.last)
    else $error("poll completion not marked as final result");

endmodule

`default_nettype wire

// File: rtl/core/descriptor_ring_tracker_unit.sv
// ----------------------------------------------------------------------------
// Descriptor ring tracker
// Host-side transmit and receive descriptor ring bookkeeping with an
// ownership bit and an occupancy count.
// ----------------------------------------------------------------------------
// Requests: a post, write-back or idle poll is taken in the idle state; a post
//   or idle poll loads its result into the output register; stalls hold it.
// Throughput: one item per cycle while idle with a free result register; a poll
//   with an interrupt reads and checks transmit, then receive descriptors.
// Reset: pointers, occupancy and store valid flags clear at once, with no
//   clearing pass; the receive buffer size register returns to 1536.
`default_nettype none

module descriptor_ring_tracker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  drt_in_if.sink           req_i,
  drt_out_if.source        rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_data_i
);
  import drt_pkg::*;

  logic [SIZE_W-1:0] buf_size_q;
  tx_mem_req_t       tx_req;
  rx_mem_req_t       rx_req;
  logic [31:0]       tx_stat;
  logic [31:0]       tx_addr;
  logic [31:0]       rx_stat;

  // Receive buffer size register, used when a descriptor is rearmed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= RX_SIZE_RESET;
    end else if (cfg_we_i) begin
      buf_size_q <= cfg_data_i;
    end
  end

  drt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .buf_size_i (buf_size_q),
    .tx_req_o   (tx_req),
    .tx_stat_i  (tx_stat),
    .tx_addr_i  (tx_addr),
    .rx_req_o   (rx_req),
    .rx_stat_i  (rx_stat)
  );

  drt_tx_ram u_tx_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tx_req),
    .stat_o (tx_stat),
    .addr_o (tx_addr)
  );

  drt_rx_ram u_rx_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rx_req),
    .stat_o (rx_stat)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Descriptor ring tracker testbench
// Drives posts, status write-backs and polls into the tracker. A behavioural
// copy of both rings predicts every result, and the monitor checks each
// result transfer field by field. The run steps through several idling
// phases and receive buffer sizes. It also holds the result channel off for
// a long stretch, so that the tracker fills up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import drt_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_AFTER    = 35;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_ITEMS  = 22;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    op_e         op;
    logic [11:0] frame_length;
    logic [31:0] buffer_address;
    logic [5:0]  slot;
    logic [31:0] status_word;
    logic        interrupt_pending;
  } ring_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [11:0] cfg_data;

  drt_in_if  req ();
  drt_out_if rsp ();

  descriptor_ring_tracker_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // Pending commands, expected results and run bookkeeping
  ring_cmd_t  pending_cmds[$];
  result_t    expected_results[$];
  ring_cmd_t  offered_cmd;
  idle_mode_e idle_mode;
  int         accepted_cmds;
  int         mismatch_count;
  int         quiet_cycles;

  // Behavioural copy of the ring state
  logic [31:0]      tx_status [TX_SLOTS];
  logic [31:0]      tx_address [TX_SLOTS];
  logic [TX_IW-1:0] tx_post_idx;
  logic [TX_IW-1:0] tx_reap_idx;
  logic [OCC_W-1:0] tx_count;
  logic [31:0]      rx_desc_copy [RX_SLOTS];
  logic [RX_IW-1:0] rx_take_idx;
  logic [11:0]      rx_refill_size;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic push_result(input kind_e kind, input logic [5:0] slot,
                             input logic [11:0] length, input logic [31:0] address,
                             input logic last);
    result_t r;
    r.kind    = kind;
    r.slot    = slot;
    r.length  = length;
    r.address = address;
    r.last    = last;
    expected_results.push_back(r);
  endtask

  // Update the ring copy for one accepted command and queue its results.
  task automatic predict_ring_results(input ring_cmd_t c);
    logic [31:0] st;
    int          visits;
    case (c.op)
      OP_POST: begin
        if (tx_count == TX_SLOTS) begin
          push_result(K_OVERFLOW, 6'(tx_post_idx), '0, '0, 1'b1);
        end else begin
          tx_address[tx_post_idx] = c.buffer_address;
          tx_status[tx_post_idx]  = {20'd0, c.frame_length};
          tx_status[tx_post_idx][OWN_BIT] = 1'b1;
          push_result(K_POST_OK, 6'(tx_post_idx), '0, '0, 1'b1);
          tx_post_idx = (tx_post_idx == TX_SLOTS - 1) ? '0 : tx_post_idx + 1'b1;
          tx_count++;
        end
      end
      OP_TX_WB: begin
        if (c.slot < TX_SLOTS) tx_status[c.slot[TX_IW-1:0]] = c.status_word;
      end
      OP_RX_WB: begin
        if (c.slot < RX_SLOTS) rx_desc_copy[c.slot[RX_IW-1:0]] = c.status_word;
      end
      default: begin
        if (c.interrupt_pending) begin
          // Reap completed transmit slots in order.
          while (tx_count != 0 && !tx_status[tx_reap_idx][OWN_BIT]) begin
            push_result(tx_status[tx_reap_idx][PKT_OK_BIT] ? K_TX_OK : K_TX_ERR,
                        6'(tx_reap_idx), '0, tx_address[tx_reap_idx], 1'b0);
            tx_status[tx_reap_idx] = '0;
            tx_reap_idx = (tx_reap_idx == TX_SLOTS - 1) ? '0 : tx_reap_idx + 1'b1;
            tx_count--;
          end
          // Take completed receive descriptors and rearm them.
          for (visits = 0; visits < RX_SLOTS && rx_desc_copy[rx_take_idx][OWN_BIT];
               visits++) begin
            st = rx_desc_copy[rx_take_idx];
            if ({st[MORE_BIT], st[PKT_OK_BIT], st[TOO_LONG_BIT]} == 3'b010) begin
              push_result(K_RX_PKT, 6'(rx_take_idx),
                          (st[11:0] > CRC_BYTES) ? st[11:0] - CRC_BYTES : 12'd0,
                          '0, 1'b0);
            end else begin
              push_result(K_RX_ERR, 6'(rx_take_idx), '0, '0, 1'b0);
            end
            rx_desc_copy[rx_take_idx] = {20'd0, rx_refill_size};
            rx_take_idx = (rx_take_idx == RX_SLOTS - 1) ? '0 : rx_take_idx + 1'b1;
          end
        end
        push_result(K_POLL_DONE, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic queue_cmd(input op_e op, input logic [11:0] frame_length,
                           input logic [31:0] buffer_address, input logic [5:0] slot,
                           input logic [31:0] status_word, input logic irq);
    ring_cmd_t c;
    c.op                = op;
    c.frame_length      = frame_length;
    c.buffer_address    = buffer_address;
    c.slot              = slot;
    c.status_word       = status_word;
    c.interrupt_pending = irq;
    pending_cmds.push_back(c);
  endtask

  // Wait until every command is taken and every result has arrived, then
  // let the tracker settle before the next step.
  task automatic settle();
    while (pending_cmds.size() != 0 || req.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: presents queued commands and predicts on each transfer.
  always @(posedge clk or negedge rst_n) begin
    int idle_pct;
    if (!rst_n) begin
      req.valid <= 1'b0;
    end else begin
      idle_pct = (idle_mode == IDLE_SEND) ? 48 : (idle_mode == IDLE_BOTH) ? 21 : 0;
      if (req.valid && req.ready) begin
        predict_ring_results(offered_cmd);
        accepted_cmds++;
      end
      if (!req.valid || req.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          offered_cmd           = pending_cmds.pop_front();
          req.valid             <= 1'b1;
          req.op                <= offered_cmd.op;
          req.frame_length      <= offered_cmd.frame_length;
          req.buffer_address    <= offered_cmd.buffer_address;
          req.slot              <= offered_cmd.slot;
          req.status_word       <= offered_cmd.status_word;
          req.interrupt_pending <= offered_cmd.interrupt_pending;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer and applies back-pressure,
  // including one long hold-off once enough commands have gone in.
  always @(posedge clk or negedge rst_n) begin
    result_t want;
    int      stall_pct;
    int      hold_left;
    bit      hold_done;
    if (!rst_n) begin
      rsp.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                    rsp.kind, rsp.result_slot));
        end else begin
          want = expected_results.pop_front();
          if (rsp.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", rsp.kind, want.kind));
          if (rsp.result_slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d",
                                      rsp.result_slot, want.slot));
          if (rsp.result_length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d",
                                      rsp.result_length, want.length));
          if (rsp.result_address !== want.address)
            report_mismatch($sformatf("address %h, expected %h",
                                      rsp.result_address, want.address));
          if (rsp.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", rsp.last, want.last));
        end
      end
      if (!hold_done && accepted_cmds >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      stall_pct = (idle_mode == IDLE_RECV) ? 48 : (idle_mode == IDLE_BOTH) ? 21 : 0;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[descriptor_ring_tracker_unit] ERROR");
      $finish;
    end
  end

  // Stimulus sequencing
  initial begin
    ring_cmd_t c;
    int        phase;
    int        n;
    int        pick;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    req.valid             = 1'b0;
    req.op                = '0;
    req.frame_length      = '0;
    req.buffer_address    = '0;
    req.slot              = '0;
    req.status_word       = '0;
    req.interrupt_pending = 1'b0;
    rsp.ready             = 1'b0;
    idle_mode             = IDLE_NONE;
    accepted_cmds         = 0;
    mismatch_count        = 0;
    quiet_cycles          = 0;

    // Ring copy after reset
    rx_refill_size = RX_SIZE_RESET;
    for (n = 0; n < TX_SLOTS; n++) begin
      tx_status[n]  = '0;
      tx_address[n] = '0;
    end
    for (n = 0; n < RX_SLOTS; n++) rx_desc_copy[n] = {20'd0, RX_SIZE_RESET};
    tx_post_idx = '0;
    tx_reap_idx = '0;
    tx_count    = '0;
    rx_take_idx = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        settle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= (phase == 1) ? 12'd0 : (phase == 2) ? 12'hFFF : 12'($urandom);
        @(posedge clk);
        rx_refill_size = cfg_data;
        cfg_we <= 1'b0;
      end
      idle_mode = idle_mode_e'(phase);

      if (phase == 0) begin
        // Idle poll, then fill the transmit ring and overflow it.
        queue_cmd(OP_POLL, 12'hFFF, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_POST, 12'h000, 32'h0000_0000, 6'h00, 32'h0, 1'b0);
        queue_cmd(OP_POST, 12'hFFF, 32'hFFFF_FFFF, 6'h00, 32'h0, 1'b1);
        queue_cmd(OP_POST, 12'h5A5, 32'h1234_5678, 6'h00, 32'h0, 1'b0);
        queue_cmd(OP_POST, 12'hA5A, 32'h8000_0001, 6'h00, 32'h0, 1'b0);
        queue_cmd(OP_POST, 12'h001, 32'h0000_0001, 6'h00, 32'h0, 1'b0);
        // Completions: one good, one failed, one beyond the ring.
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd0, 32'h0800_0000, 1'b0);
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd1, 32'h0000_0000, 1'b0);
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd63, 32'hFFFF_FFFF, 1'b0);
        // Receive: short frames, too-long and more-fragments errors.
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd0, 32'h8800_0004, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd1, 32'h8800_0003, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd2, 32'h8840_0FFF, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd3, 32'hC800_0100, 1'b0);
        queue_cmd(OP_POLL, 12'h0, 32'h0, 6'd0, 32'h0, 1'b1);
        // Refill the ring and complete everything for the longest poll.
        queue_cmd(OP_POST, 12'h040, 32'hDEAD_BEEF, 6'd0, 32'h0, 1'b0);
        queue_cmd(OP_POST, 12'h800, 32'h0000_FFFF, 6'd0, 32'h0, 1'b0);
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd2, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd3, 32'h0800_0000, 1'b0);
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd0, 32'h0000_0001, 1'b0);
        queue_cmd(OP_TX_WB, 12'h0, 32'h0, 6'd1, 32'h0800_0000, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd0, 32'h8800_0FFF, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd1, 32'h8000_0040, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd2, 32'h8800_0005, 1'b0);
        queue_cmd(OP_RX_WB, 12'h0, 32'h0, 6'd3, 32'h8800_0040, 1'b0);
        queue_cmd(OP_POLL, 12'h0, 32'h0, 6'd0, 32'h0, 1'b1);
      end

      // Random traffic, mostly well-formed completions with random content.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        c.op = (pick < 30) ? OP_POST : (pick < 50) ? OP_TX_WB :
               (pick < 75) ? OP_RX_WB : OP_POLL;
        c.frame_length      = 12'($urandom);
        c.buffer_address    = $urandom;
        c.slot              = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                          : 6'($urandom_range(0, 3));
        c.status_word       = $urandom;
        c.interrupt_pending = (c.op == OP_POLL) ? ($urandom_range(0, 9) != 0)
                                                : 1'($urandom);
        if (c.op == OP_TX_WB && $urandom_range(0, 4) != 0) c.status_word[OWN_BIT] = 1'b0;
        if (c.op == OP_RX_WB && $urandom_range(0, 4) != 0) begin
          c.status_word[OWN_BIT] = 1'b1;
          if ($urandom_range(0, 1)) begin
            c.status_word[MORE_BIT]     = 1'b0;
            c.status_word[PKT_OK_BIT]   = 1'b1;
            c.status_word[TOO_LONG_BIT] = 1'b0;
          end
          if ($urandom_range(0, 3) == 0) c.status_word[11:0] = 12'($urandom_range(0, 8));
        end
        pending_cmds.push_back(c);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("[descriptor_ring_tracker_unit] OK");
    end else begin
      $display("[descriptor_ring_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
